### sv/label_neighbour_list_builder_top_defines.svh
// Assertion macros shared by the neighbour list builder RTL.
// No dependencies; simulation builds get live checks, synthesis gets empty bodies.
`ifndef LABEL_NEIGHBOUR_LIST_BUILDER_TOP_DEFINES_SVH
`define LABEL_NEIGHBOUR_LIST_BUILDER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define LNLB_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("neighbour list builder check failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define LNLB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("neighbour list builder check failed");
`else
`define LNLB_ASSERT_NOW(name, clk, rst, ante, cons)
`define LNLB_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

### sv/lnlb_pkg.sv
// Shared constants, types and helper functions of the neighbour list builder.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package lnlb_pkg;

   localparam int LABEL_COUNT = 4096;
   localparam int LIST_SLOTS  = 5;
   localparam int LABEL_W     = 12;
   localparam int COUNT_W     = 3;
   localparam int ADDR_W      = (LABEL_COUNT > 2) ? $clog2(LABEL_COUNT) : 1;
   localparam int LEN_W       = $clog2(LIST_SLOTS + 1);
   localparam int NEIGHBOURS  = 4;
   localparam int STEP_W      = $clog2(NEIGHBOURS);
   localparam int SHOWN_SLOTS = 5;
   localparam int COUNT_MAX   = 7;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef logic [LABEL_W-1:0] label_type;
   typedef label_type [LIST_SLOTS-1:0] row_type;
   typedef logic [LEN_W-1:0] len_type;
   typedef logic [ADDR_W-1:0] addr_type;

   function automatic addr_type label_to_addr(input label_type label);
      logic [31:0] wide;
      wide = 32'(label);
      return wide[ADDR_W-1:0];
   endfunction

   function automatic logic label_in_range(input label_type label);
      return 32'(label) < 32'(LABEL_COUNT);
   endfunction

endpackage

`default_nettype wire

### sv/lnlb_if.sv
// Valid/ready channel interfaces for pixel/read requests and list responses.
// Depends on lnlb_pkg for field widths.
`default_nettype none

interface lnlb_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [lnlb_pkg::LABEL_W-1:0] centre_label;
   logic [lnlb_pkg::LABEL_W-1:0] left_label;
   logic [lnlb_pkg::LABEL_W-1:0] next_row_label;
   logic [lnlb_pkg::LABEL_W-1:0] right_label;
   logic [lnlb_pkg::LABEL_W-1:0] prev_row_label;

   modport source (
      output valid, operation, centre_label, left_label, next_row_label,
             right_label, prev_row_label,
      input  ready
   );
   modport sink (
      input  valid, operation, centre_label, left_label, next_row_label,
             right_label, prev_row_label,
      output ready
   );
endinterface

interface lnlb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lnlb_pkg::COUNT_W-1:0] neighbour_count;
   logic [lnlb_pkg::LABEL_W-1:0] neighbour_a;
   logic [lnlb_pkg::LABEL_W-1:0] neighbour_b;
   logic [lnlb_pkg::LABEL_W-1:0] neighbour_c;
   logic [lnlb_pkg::LABEL_W-1:0] neighbour_d;
   logic [lnlb_pkg::LABEL_W-1:0] neighbour_e;

   modport source (
      output valid, neighbour_count, neighbour_a, neighbour_b, neighbour_c,
             neighbour_d, neighbour_e,
      input  ready
   );
   modport sink (
      input  valid, neighbour_count, neighbour_a, neighbour_b, neighbour_c,
             neighbour_d, neighbour_e,
      output ready
   );
endinterface

`default_nettype wire

### sv/label_neighbour_list_builder_top.sv
// Neighbour list builder: count and entry memories, list sequencer, response register.
// Depends on lnlb_pkg, the channel interfaces in lnlb_if.sv and the assertion macros.
//
// For every region label the block keeps up to LIST_SLOTS distinct neighbouring labels.
// A pixel beat (operation 0) with a nonzero, in-range centre goes from accept through a
// load state for the registered read of the label's count and entry row, four steps in
// which a single membership compare unit checks left, next row, right and previous row
// neighbours in turn against the filled part of the row, and a write-back state before
// the next ready. A pixel beat with a zero or out-of-range centre is taken without
// leaving the idle state. A read beat (operation 1) passes through the load state and
// leaves its result in an output register, so further pixel beats are taken while the
// result waits; a second read waits until the register is free. After reset the count
// memory is cleared one label per cycle, so req_bus.ready stays low until every label is cleared.
`default_nettype none
`include "label_neighbour_list_builder_top_defines.svh"

module label_neighbour_list_builder_top (
   input  wire logic  clock,
   input  wire logic  reset,
   lnlb_req_if.sink   req_bus,
   lnlb_rsp_if.source rsp_bus
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_STEP,
      ST_WRITE
   } state_type;

   state_type state_ff, state_in;
   lnlb_pkg::addr_type  clr_ff, clr_in;
   logic                op_ff, op_in;
   lnlb_pkg::label_type centre_ff, centre_in;
   lnlb_pkg::addr_type  addr_ff, addr_in;
   logic                in_range_ff, in_range_in;
   lnlb_pkg::label_type nb_ff [lnlb_pkg::NEIGHBOURS];
   lnlb_pkg::label_type nb_in [lnlb_pkg::NEIGHBOURS];
   logic [lnlb_pkg::STEP_W-1:0] step_ff, step_in;
   lnlb_pkg::row_type   row_ff, row_in;
   lnlb_pkg::len_type   len_ff, len_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [lnlb_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   lnlb_pkg::label_type rsp_nb_ff [lnlb_pkg::SHOWN_SLOTS];
   lnlb_pkg::label_type rsp_nb_in [lnlb_pkg::SHOWN_SLOTS];

   // Count memory (cleared after reset) and entry row memory (never cleared).
   lnlb_pkg::len_type   len_mem   [lnlb_pkg::LABEL_COUNT];
   lnlb_pkg::row_type   entry_mem [lnlb_pkg::LABEL_COUNT];
   lnlb_pkg::len_type   len_rd_ff;
   lnlb_pkg::row_type   entry_rd_ff;
   logic                rd_en;
   lnlb_pkg::addr_type  rd_addr;
   logic                len_we;
   lnlb_pkg::addr_type  len_waddr;
   lnlb_pkg::len_type   len_wdata;
   logic                entry_we;

   logic                req_accept;
   logic                rsp_free;

   // Shared membership compare unit.
   lnlb_pkg::label_type cur_nb;
   logic                dup_hit;
   logic                append_ok;
   lnlb_pkg::row_type   row_app;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign rd_en         = req_accept;
   assign rd_addr       = lnlb_pkg::label_to_addr(req_bus.centre_label);

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      if (rd_en) begin
         len_rd_ff <= len_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[addr_ff] <= row_ff;
      end
      if (rd_en) begin
         entry_rd_ff <= entry_mem[rd_addr];
      end
   end

   always_comb begin
      cur_nb  = nb_ff[step_ff];
      dup_hit = 1'b0;
      row_app = row_ff;
      for (int k = 0; k < lnlb_pkg::LIST_SLOTS; k++) begin
         if ((lnlb_pkg::LEN_W'(k) < len_ff) && (row_ff[k] == cur_nb)) begin
            dup_hit = 1'b1;
         end
         if (lnlb_pkg::LEN_W'(k) == len_ff) begin
            row_app[k] = cur_nb;
         end
      end
      append_ok = (len_ff < lnlb_pkg::LEN_W'(lnlb_pkg::LIST_SLOTS)) &&
                  (cur_nb != '0) && (cur_nb != centre_ff) && !dup_hit;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      centre_in    = centre_ff;
      addr_in      = addr_ff;
      in_range_in  = in_range_ff;
      nb_in        = nb_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_nb_in    = rsp_nb_ff;
      len_we       = 1'b0;
      len_waddr    = addr_ff;
      len_wdata    = len_ff;
      entry_we     = 1'b0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            len_we    = 1'b1;
            len_waddr = clr_ff;
            len_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == lnlb_pkg::ADDR_W'(lnlb_pkg::LABEL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               op_in       = req_bus.operation;
               centre_in   = req_bus.centre_label;
               addr_in     = rd_addr;
               in_range_in = lnlb_pkg::label_in_range(req_bus.centre_label);
               nb_in[0]    = req_bus.left_label;
               nb_in[1]    = req_bus.next_row_label;
               nb_in[2]    = req_bus.right_label;
               nb_in[3]    = req_bus.prev_row_label;
               if ((req_bus.operation == lnlb_pkg::OP_READ) ||
                   ((req_bus.centre_label != '0) && in_range_in)) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            if (op_ff == lnlb_pkg::OP_READ) begin
               // Hold the read data until the response register is free.
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = '0;
                  for (int j = 0; j < lnlb_pkg::SHOWN_SLOTS; j++) begin
                     rsp_nb_in[j] = '0;
                  end
                  if (in_range_ff) begin
                     if (32'(len_rd_ff) > 32'(lnlb_pkg::COUNT_MAX)) begin
                        rsp_count_in = lnlb_pkg::COUNT_W'(lnlb_pkg::COUNT_MAX);
                     end else begin
                        rsp_count_in = lnlb_pkg::COUNT_W'(len_rd_ff);
                     end
                     for (int k = 0; k < lnlb_pkg::LIST_SLOTS; k++) begin
                        if ((k < lnlb_pkg::SHOWN_SLOTS) &&
                            (lnlb_pkg::LEN_W'(k) < len_rd_ff)) begin
                           rsp_nb_in[k] = entry_rd_ff[k];
                        end
                     end
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               row_in   = entry_rd_ff;
               len_in   = len_rd_ff;
               step_in  = '0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (append_ok) begin
               row_in = row_app;
               len_in = len_ff + 1'b1;
            end
            if (step_ff == lnlb_pkg::STEP_W'(lnlb_pkg::NEIGHBOURS - 1)) begin
               state_in = ST_WRITE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            len_we   = 1'b1;
            entry_we = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      centre_ff    <= centre_in;
      addr_ff      <= addr_in;
      in_range_ff  <= in_range_in;
      nb_ff        <= nb_in;
      step_ff      <= step_in;
      row_ff       <= row_in;
      len_ff       <= len_in;
      rsp_count_ff <= rsp_count_in;
      rsp_nb_ff    <= rsp_nb_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.neighbour_count = rsp_count_ff;
   assign rsp_bus.neighbour_a     = rsp_nb_ff[0];
   assign rsp_bus.neighbour_b     = rsp_nb_ff[1];
   assign rsp_bus.neighbour_c     = rsp_nb_ff[2];
   assign rsp_bus.neighbour_d     = rsp_nb_ff[3];
   assign rsp_bus.neighbour_e     = rsp_nb_ff[4];

   // A list being built never grows past its slot count.
   `LNLB_ASSERT_NOW(a_len_bound, clock, reset, state_ff == ST_STEP,
      len_ff <= lnlb_pkg::LEN_W'(lnlb_pkg::LIST_SLOTS))
   // The last neighbour step always leads to write-back.
   `LNLB_ASSERT_NEXT(a_step_to_write, clock, reset,
      (state_ff == ST_STEP) && (step_ff == lnlb_pkg::STEP_W'(lnlb_pkg::NEIGHBOURS - 1)),
      state_ff == ST_WRITE)
   // The count memory is written only by the clearing pass or write-back.
   `LNLB_ASSERT_NOW(a_len_write_state, clock, reset, len_we,
      (state_ff == ST_CLEAR) || (state_ff == ST_WRITE))
   // A pending result is not overwritten by a later read.
   `LNLB_ASSERT_NEXT(a_rsp_held, clock, reset,
      rsp_valid_ff && !rsp_bus.ready,
      rsp_valid_ff && $stable(rsp_count_ff) && $stable(rsp_nb_ff[0]))

endmodule

`default_nettype wire

### tb/tb_label_neighbour_list_builder_top.sv
// Self-checking testbench for label_neighbour_list_builder_top: drives pixel and read beats,
// predicts each label's neighbour list and checks every read response field by field.
// Depends on lnlb_pkg, the channel interfaces in lnlb_if.sv and the top level RTL.
module tb_label_neighbour_list_builder_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1250;
   localparam int PAUSE_AT     = RANDOM_ITEMS / 2;
   localparam int POOL_SIZE    = 12;
   localparam int POOL_REFRESH = 80;
   localparam int DRAIN_CYCLES = 20;
   // The count memory clear after reset alone keeps ready low while every label is cleared.
   localparam int IDLE_LIMIT   = 4 * lnlb_pkg::LABEL_COUNT;

   typedef struct packed {
      lnlb_pkg::op_type    operation;
      lnlb_pkg::label_type centre;
      lnlb_pkg::label_type left;
      lnlb_pkg::label_type next_row;
      lnlb_pkg::label_type right;
      lnlb_pkg::label_type prev_row;
   } pixel_beat_type;

   typedef struct packed {
      logic [lnlb_pkg::COUNT_W-1:0]                    count;
      lnlb_pkg::label_type [lnlb_pkg::SHOWN_SLOTS-1:0] slot;
   } list_view_type;

   typedef struct packed {
      lnlb_pkg::op_type             operation;
      lnlb_pkg::label_type          centre;
      lnlb_pkg::label_type          left;
      lnlb_pkg::label_type          next_row;
      lnlb_pkg::label_type          right;
      lnlb_pkg::label_type          prev_row;
      logic                         typed;
      logic [lnlb_pkg::COUNT_W-1:0] count;
      lnlb_pkg::label_type          a;
      lnlb_pkg::label_type          b;
      lnlb_pkg::label_type          c;
      lnlb_pkg::label_type          d;
      lnlb_pkg::label_type          e;
   } directed_row_type;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_COIN,
      RX_HOLD
   } rx_mode_type;

   // Rows marked typed carry a response that is obvious from the stimulus; the others
   // are checked against the list predictor.
   directed_row_type directed_rows [21] = '{
      '{lnlb_pkg::OP_READ,  12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 1'b1, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_READ,  12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000, 1'b1, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_READ,  12'h001, 12'h000, 12'h000, 12'h000, 12'h000, 1'b1, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_PIXEL, 12'h000, 12'h005, 12'h006, 12'h007, 12'h008, 1'b0, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_READ,  12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 1'b1, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_PIXEL, 12'hFFF, 12'h001, 12'hFFF, 12'h000, 12'h001, 1'b0, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_READ,  12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000, 1'b1, 3'd1,
        12'h001, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_PIXEL, 12'hFFF, 12'h800, 12'h002, 12'h800, 12'h003, 1'b0, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_READ,  12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_PIXEL, 12'hFFF, 12'hFFE, 12'h005, 12'h006, 12'h007, 1'b0, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_READ,  12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000, 1'b1, 3'd5,
        12'h001, 12'h800, 12'h002, 12'h003, 12'hFFE},
      '{lnlb_pkg::OP_PIXEL, 12'h001, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_PIXEL, 12'h001, 12'hAAA, 12'h555, 12'hFFF, 12'h001, 1'b0, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_READ,  12'h001, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_PIXEL, 12'h002, 12'h002, 12'h002, 12'h002, 12'h002, 1'b0, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_READ,  12'h002, 12'h000, 12'h000, 12'h000, 12'h000, 1'b1, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_PIXEL, 12'h800, 12'h7FF, 12'h400, 12'h3FF, 12'h200, 1'b0, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_READ,  12'h800, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_PIXEL, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_READ,  12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 1'b1, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{lnlb_pkg::OP_READ,  12'h555, 12'h000, 12'h000, 12'h000, 12'h000, 1'b1, 3'd0,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   lnlb_req_if req_bus();
   lnlb_rsp_if rsp_bus();

   label_neighbour_list_builder_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #4 clock = ~clock;

   // Predicted contents of the count and entry memories.
   int unsigned         list_len [lnlb_pkg::LABEL_COUNT];
   lnlb_pkg::label_type list_slot [lnlb_pkg::LABEL_COUNT][lnlb_pkg::LIST_SLOTS];

   list_view_type       pending_lists [$];
   lnlb_pkg::label_type label_pool [POOL_SIZE];
   int                  mismatch_count = 0;
   int                  idle_cycles = 0;
   int                  burst_left = 0;
   rx_mode_type         rx_mode = RX_STEADY;
   int                  rx_left = 0;
   int                  rx_hold = 0;

   function automatic void append_neighbour(lnlb_pkg::label_type centre,
                                            lnlb_pkg::label_type nb);
      int unsigned n;
      int unsigned k;
      bit          seen;
      n = list_len[centre];
      seen = 1'b0;
      if (n < lnlb_pkg::LIST_SLOTS && nb != '0 && nb != centre) begin
         for (k = 0; k < n; k++)
            if (list_slot[centre][k] == nb) seen = 1'b1;
         if (!seen) begin
            list_slot[centre][n] = nb;
            list_len[centre] = n + 1;
         end
      end
   endfunction

   function automatic void apply_pixel(pixel_beat_type beat);
      if (beat.centre != '0 && 32'(beat.centre) < lnlb_pkg::LABEL_COUNT) begin
         append_neighbour(beat.centre, beat.left);
         append_neighbour(beat.centre, beat.next_row);
         append_neighbour(beat.centre, beat.right);
         append_neighbour(beat.centre, beat.prev_row);
      end
   endfunction

   function automatic list_view_type read_list(lnlb_pkg::label_type centre);
      list_view_type view;
      int unsigned   n;
      int unsigned   j;
      view = '0;
      if (32'(centre) < lnlb_pkg::LABEL_COUNT) begin
         n = list_len[centre];
         view.count = (n > lnlb_pkg::COUNT_MAX) ?
                      lnlb_pkg::COUNT_W'(lnlb_pkg::COUNT_MAX) : lnlb_pkg::COUNT_W'(n);
         for (j = 0; j < lnlb_pkg::SHOWN_SLOTS && j < n && j < lnlb_pkg::LIST_SLOTS; j++)
            view.slot[j] = list_slot[centre][j];
      end
      return view;
   endfunction

   function automatic void compare_list(list_view_type want, list_view_type got);
      string slot_names [lnlb_pkg::SHOWN_SLOTS] = '{"neighbour_a", "neighbour_b",
                                                    "neighbour_c", "neighbour_d",
                                                    "neighbour_e"};
      int j;
      if (want.count !== got.count) begin
         $display("%0t: neighbour_count expected %0d actual %0d", $time, want.count, got.count);
         mismatch_count++;
      end
      for (j = 0; j < lnlb_pkg::SHOWN_SLOTS; j++) begin
         if (want.slot[j] !== got.slot[j]) begin
            $display("%0t: %s expected 0x%03h actual 0x%03h", $time, slot_names[j],
                     want.slot[j], got.slot[j]);
            mismatch_count++;
         end
      end
   endfunction

   function automatic void refresh_pool();
      int i;
      for (i = 0; i < POOL_SIZE; i++)
         label_pool[i] = lnlb_pkg::label_type'($urandom_range(1, 2**lnlb_pkg::LABEL_W - 1));
   endfunction

   // Mostly labels from a small pool so that lists fill, repeat and overflow; the rest
   // are zero, the centre itself or drawn from the full label range.
   function automatic lnlb_pkg::label_type pick_label(lnlb_pkg::label_type centre);
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 18) return centre;
      if (roll < 35) return lnlb_pkg::label_type'($urandom);
      return label_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   function automatic pixel_beat_type random_beat();
      pixel_beat_type beat;
      int             roll;
      roll = $urandom_range(99);
      beat.operation = ($urandom_range(99) < 30) ? lnlb_pkg::OP_READ : lnlb_pkg::OP_PIXEL;
      if (roll < 4)       beat.centre = '0;
      else if (roll < 14) beat.centre = lnlb_pkg::label_type'($urandom);
      else                beat.centre = label_pool[$urandom_range(POOL_SIZE - 1)];
      beat.left     = pick_label(beat.centre);
      beat.next_row = pick_label(beat.centre);
      beat.right    = pick_label(beat.centre);
      beat.prev_row = pick_label(beat.centre);
      return beat;
   endfunction

   // Presents one beat from the falling edge and holds it until it is taken.
   task automatic drive_beat(pixel_beat_type beat, logic typed, list_view_type typed_view);
      list_view_type expected;
      @(negedge clock);
      req_bus.valid          <= 1'b1;
      req_bus.operation      <= beat.operation;
      req_bus.centre_label   <= beat.centre;
      req_bus.left_label     <= beat.left;
      req_bus.next_row_label <= beat.next_row;
      req_bus.right_label    <= beat.right;
      req_bus.prev_row_label <= beat.prev_row;
      do @(posedge clock); while (!req_bus.ready);
      if (beat.operation == lnlb_pkg::OP_READ) begin
         expected = typed ? typed_view : read_list(beat.centre);
         pending_lists = {pending_lists, expected};
      end else begin
         apply_pixel(beat);
      end
   endtask

   task automatic idle_sender(int cycles);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic pace_sender();
      if (burst_left == 0) begin
         idle_sender($urandom_range(1, 6));
         burst_left = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      end else begin
         burst_left--;
      end
   endtask

   initial begin
      directed_row_type row;
      pixel_beat_type   beat;
      list_view_type    view;
      int               i;

      req_bus.valid          = 1'b0;
      req_bus.operation      = lnlb_pkg::OP_PIXEL;
      req_bus.centre_label   = '0;
      req_bus.left_label     = '0;
      req_bus.next_row_label = '0;
      req_bus.right_label    = '0;
      req_bus.prev_row_label = '0;
      rsp_bus.ready          = 1'b0;
      refresh_pool();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(directed_rows); i++) begin
         row = directed_rows[i];
         beat = '{row.operation, row.centre, row.left, row.next_row, row.right,
                  row.prev_row};
         view.count = row.count;
         view.slot  = {row.e, row.d, row.c, row.b, row.a};
         drive_beat(beat, row.typed, view);
         pace_sender();
      end

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % POOL_REFRESH == 0) refresh_pool();
         if (i == PAUSE_AT) begin
            // Let the response side run dry before going on.
            idle_sender(1);
            while (pending_lists.size() != 0) @(posedge clock);
         end
         drive_beat(random_beat(), 1'b0, '0);
         pace_sender();
      end

      idle_sender(1);
      while (pending_lists.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // The response side alternates between always ready, coin flips and long stalls.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(2));
         rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      case (rx_mode)
         RX_STEADY: rsp_bus.ready <= 1'b1;
         RX_COIN:   rsp_bus.ready <= 1'($urandom_range(1));
         default: begin
            if (rx_hold == 0) rx_hold = $urandom_range(1, 12);
            rx_hold--;
            rsp_bus.ready <= (rx_hold == 0);
         end
      endcase
   end

   always @(posedge clock) begin
      list_view_type seen_view;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_view.count = rsp_bus.neighbour_count;
         seen_view.slot  = {rsp_bus.neighbour_e, rsp_bus.neighbour_d, rsp_bus.neighbour_c,
                            rsp_bus.neighbour_b, rsp_bus.neighbour_a};
         if (pending_lists.size() == 0) begin
            $display("%0t: response beat with none expected, expected nothing actual count %0d",
                     $time, seen_view.count);
            mismatch_count++;
         end else begin
            compare_list(pending_lists.pop_front(), seen_view);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
